[rtl/core/imhu_pkg.sv]
`default_nettype none
package imhu_pkg;
  localparam int SLOTS    = 1024;
  localparam int KEY_BITS = 40;
  localparam int IDX_W    = $clog2(SLOTS);
  localparam int SITE_W   = 10;
  localparam int CNT_W    = IDX_W + 1;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [SITE_W-1:0]   site_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_UPDATE = 2'd1,
    MODE_OFFSET = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  // shared comparator request/answer
  typedef struct packed {
    key_t  a_key;
    site_t a_site;
    key_t  b_key;
    site_t b_site;
  } cmp_req_t;

  typedef struct packed {
    logic a_lt;      // key a < key b
    logic a_gt;      // key a > key b
    logic a_before;  // a < b, ties by lower site
  } cmp_rsp_t;
endpackage
`default_nettype wire

[rtl/core/imhu_cmp.sv]
`default_nettype none
module imhu_cmp (
  input  wire imhu_pkg::cmp_req_t req,
  output imhu_pkg::cmp_rsp_t      rsp
);
  import imhu_pkg::*;

  // magnitude compares plus site tiebreak
  always_comb begin
    rsp.a_lt     = req.a_key < req.b_key;
    rsp.a_gt     = req.a_key > req.b_key;
    rsp.a_before = rsp.a_lt || ((req.a_key == req.b_key) && (req.a_site < req.b_site));
  end
endmodule
`default_nettype wire

[rtl/core/indexed_min_heap_update_key_unit.sv]
`default_nettype none
// Indexed min-heap with insert, update-key and subtract-from-all. One word is
// taken per start while busy is low; exactly one result appears later with
// done high for a single cycle and cannot be held off. Timing is set by one
// single-port heap memory and one shared comparator: an insert or upward move
// reads and compares the parent at each level, a downward move reads and
// compares both children and then writes (the heap is up to 10 levels deep).
// A rejected or unused-mode word only reads the root; subtract sweeps every
// held entry, reading and writing each in turn. Done rises in the same cycle
// that busy falls.
module indexed_min_heap_update_key_unit (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  output logic                   busy,
  input  wire [1:0]              mode,
  input  wire [9:0]              site,
  input  wire [39:0]             new_key,
  input  wire [39:0]             offset,
  output logic                   done,
  output logic [39:0]            root_key,
  output logic [9:0]             root_site,
  output logic [10:0]            entry_total,
  output logic                   rejected
);
  import imhu_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MAP_RD, S_MAP_WT, S_CHK, S_UP_RD, S_UP_WT, S_UP_CMP,
    S_DN_L, S_DN_LW, S_DN_R, S_DN_RW, S_DN_SW, S_OFF_RD, S_OFF_WR,
    S_ROOT, S_ROOT_WT
  } state_t;

  // heap memory: key and site per slot; site map memory
  logic [KEY_BITS+SITE_W-1:0] heap_mem [SLOTS];
  idx_t map_mem [SLOTS];

  logic heap_we;
  idx_t heap_addr;
  logic [KEY_BITS+SITE_W-1:0] heap_wd, heap_rd;
  logic map_we;
  site_t map_addr;
  idx_t map_wd, map_rd;

  always_ff @(posedge clk) begin
    if (heap_we) heap_mem[heap_addr] <= heap_wd;
    heap_rd <= heap_mem[heap_addr];
  end
  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_addr] <= map_wd;
    map_rd <= map_mem[map_addr];
  end

  state_t state;
  mode_t  op;
  site_t  op_site;
  key_t   op_key;
  key_t   op_off;
  cnt_t   count;
  idx_t   cur;        // slot holding the moving entry
  idx_t   oth;        // chosen child in a downward move
  key_t   oth_key;
  site_t  oth_site;
  cnt_t   sweep;

  cmp_req_t creq;
  cmp_rsp_t crsp;
  imhu_cmp u_cmp (.req(creq), .rsp(crsp));

  wire [KEY_BITS-1:0] rd_key  = heap_rd[KEY_BITS+SITE_W-1:SITE_W];
  wire [SITE_W-1:0]   rd_site = heap_rd[SITE_W-1:0];
  wire [IDX_W:0] lchild = {cur, 1'b1};
  wire [IDX_W:0] rchild = {cur, 1'b0} + (IDX_W+1)'(2);
  wire idx_t     parent = idx_t'((cur - idx_t'(1)) >> 1);

  // comparator operand select
  always_comb begin
    creq.a_key  = op_key;
    creq.a_site = op_site;
    creq.b_key  = rd_key;
    creq.b_site = rd_site;
    unique case (state)
      S_DN_LW, S_DN_RW: begin
        creq.a_key  = rd_key;
        creq.a_site = rd_site;
        creq.b_key  = oth_key;
        creq.b_site = oth_site;
      end
      S_OFF_WR: begin
        creq.a_key  = rd_key;
        creq.b_key  = op_off;
      end
      default: ;
    endcase
  end

  // memory port drive
  always_comb begin
    heap_we = 1'b0; heap_addr = cur; heap_wd = {op_key, op_site};
    map_we = 1'b0; map_addr = op_site; map_wd = cur;
    unique case (state)
      S_IDLE:   map_addr = site;
      S_UP_RD, S_UP_WT: heap_addr = parent;
      S_UP_CMP: if (cur != '0 && crsp.a_lt) begin
        // parent moves down into cur
        heap_we = 1'b1; heap_addr = cur; heap_wd = heap_rd;
        map_we = 1'b1; map_addr = rd_site; map_wd = cur;
      end else begin
        heap_we = 1'b1;
        map_we  = 1'b1;
      end
      S_DN_L:   heap_addr = idx_t'(lchild);
      S_DN_R:   heap_addr = idx_t'(rchild);
      S_DN_SW:  if (oth != cur) begin
        heap_we = 1'b1; heap_wd = {oth_key, oth_site};
        map_we = 1'b1; map_addr = oth_site; map_wd = cur;
      end else begin
        heap_we = 1'b1;
        map_we  = 1'b1;
      end
      S_OFF_RD: heap_addr = idx_t'(sweep);
      S_OFF_WR: begin
        heap_we = 1'b1; heap_addr = idx_t'(sweep);
        heap_wd = {(crsp.a_gt ? rd_key - op_off : key_t'(0)), rd_site};
      end
      S_ROOT:   heap_addr = '0;
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; count <= '0; done <= 1'b0; rejected <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          op <= mode_t'(mode); op_site <= site; op_key <= new_key; op_off <= offset;
          rejected <= 1'b0; sweep <= '0;
          unique case (mode_t'(mode))
            MODE_INSERT: if (count == cnt_t'(SLOTS)) begin
              rejected <= 1'b1; state <= S_ROOT;
            end else begin
              cur <= idx_t'(count); count <= count + cnt_t'(1);
              state <= (count == '0) ? S_UP_CMP : S_UP_RD;
            end
            MODE_UPDATE: state <= S_MAP_RD;
            MODE_OFFSET: state <= S_OFF_RD;
            default:     state <= S_ROOT;
          endcase
        end
        S_MAP_RD: begin cur <= map_rd; state <= S_MAP_WT; end
        S_MAP_WT: state <= S_CHK;
        S_CHK: begin
          if ({1'b0, cur} >= count || rd_site != op_site || rd_key == op_key)
            state <= S_ROOT;
          else if (op_key > rd_key) begin
            oth <= cur; oth_key <= op_key; oth_site <= op_site; state <= S_DN_L;
          end else state <= (cur == '0) ? S_UP_CMP : S_UP_RD;
        end
        S_UP_RD: state <= S_UP_WT;
        S_UP_WT: state <= S_UP_CMP;
        S_UP_CMP: begin
          // root slot has nothing above: the moving entry lands there
          if (cur != '0 && crsp.a_lt) begin
            cur <= parent;
            state <= (parent == '0) ? S_UP_CMP : S_UP_RD;
          end else state <= S_ROOT;
        end
        S_DN_L: state <= (lchild < (IDX_W+1)'(count)) ? S_DN_LW : S_DN_SW;
        S_DN_LW: begin
          if (crsp.a_before) begin
            oth <= idx_t'(lchild); oth_key <= rd_key; oth_site <= rd_site;
          end
          state <= S_DN_R;
        end
        S_DN_R: state <= (rchild < (IDX_W+1)'(count)) ? S_DN_RW : S_DN_SW;
        S_DN_RW: begin
          if (crsp.a_before) begin
            oth <= idx_t'(rchild); oth_key <= rd_key; oth_site <= rd_site;
          end
          state <= S_DN_SW;
        end
        S_DN_SW: begin
          if (oth != cur) begin
            cur <= oth; oth_key <= op_key; oth_site <= op_site; state <= S_DN_L;
          end else state <= S_ROOT;
        end
        S_OFF_RD: state <= (sweep == count) ? S_ROOT : S_OFF_WR;
        S_OFF_WR: begin sweep <= sweep + cnt_t'(1); state <= S_OFF_RD; end
        S_ROOT: state <= S_ROOT_WT;
        S_ROOT_WT: begin
          done <= 1'b1;
          root_key  <= (count == '0) ? key_t'(0) : rd_key;
          root_site <= (count == '0) ? site_t'(0) : rd_site;
          entry_total <= count;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= cnt_t'(SLOTS))
    else $error("count overflow");
  assert property (@(posedge clk) disable iff (rst) done |-> $past(state) == S_ROOT_WT)
    else $error("done outside result state");
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held two cycles");
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("start not taken");
  assert property (@(posedge clk) disable iff (rst) rejected |-> op == MODE_INSERT)
    else $error("reject on non-insert");
endmodule
`default_nettype wire

[test/tb.sv]
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import imhu_pkg::*;

  localparam int CYCLE_LIMIT = 20_000_000;

  typedef struct {
    key_t  key;
    site_t site;
    cnt_t  total;
    logic  rej;
  } heap_view_t;

  typedef struct {
    mode_t      md;
    site_t      st;
    key_t       k;
    key_t       off;
    bit         fixed;
    heap_view_t want;
  } word_row_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic [1:0]  mode = '0;
  logic [9:0]  site = '0;
  logic [39:0] new_key = '0;
  logic [39:0] offset = '0;
  wire         busy, done, rejected;
  wire [39:0]  root_key;
  wire [9:0]   root_site;
  wire [10:0]  entry_total;

  indexed_min_heap_update_key_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode), .site(site),
    .new_key(new_key), .offset(offset), .done(done), .root_key(root_key),
    .root_site(root_site), .entry_total(entry_total), .rejected(rejected)
  );

  always #5 clk = ~clk;

  // shadow heap
  key_t  hk_key[SLOTS];
  site_t hk_site[SLOTS];
  idx_t  site_pos[SLOTS];
  bit    site_known[SLOTS];
  int    held = 0;

  heap_view_t pending_roots[$];
  int errors = 0;
  int cycles = 0;

  function automatic void slot_swap(int a, int b);
    key_t  k;
    site_t s;
    k = hk_key[a]; s = hk_site[a];
    hk_key[a] = hk_key[b]; hk_site[a] = hk_site[b];
    hk_key[b] = k; hk_site[b] = s;
    site_pos[hk_site[a]] = idx_t'(a);
    site_pos[hk_site[b]] = idx_t'(b);
  endfunction

  function automatic void rise(int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (hk_key[p] > hk_key[i]) begin
        slot_swap(p, i);
        i = p;
      end else break;
    end
  endfunction

  function automatic bit goes_first(int c, int m);
    return hk_key[c] < hk_key[m] || (hk_key[c] == hk_key[m] && hk_site[c] < hk_site[m]);
  endfunction

  function automatic void sink(int i);
    int m;
    forever begin
      m = i;
      if (2*i+1 < held && goes_first(2*i+1, m)) m = 2*i+1;
      if (2*i+2 < held && goes_first(2*i+2, m)) m = 2*i+2;
      if (m == i) break;
      slot_swap(i, m);
      i = m;
    end
  endfunction

  function automatic heap_view_t apply_word(mode_t md, site_t st, key_t k, key_t off);
    heap_view_t v;
    int s;
    key_t old;
    v.rej = 0;
    case (md)
      MODE_INSERT: begin
        if (held >= SLOTS) v.rej = 1;
        else begin
          hk_key[held] = k; hk_site[held] = st;
          site_pos[st] = idx_t'(held); site_known[st] = 1;
          held++;
          rise(held - 1);
        end
      end
      MODE_UPDATE: begin
        s = site_pos[st];
        if (s < held && hk_site[s] == st) begin
          old = hk_key[s];
          hk_key[s] = k;
          if (k > old) sink(s);
          else if (k < old) rise(s);
        end
      end
      MODE_OFFSET: begin
        for (int i = 0; i < held; i++) hk_key[i] = (hk_key[i] > off) ? hk_key[i] - off : '0;
      end
      default: ;
    endcase
    v.key   = held > 0 ? hk_key[0] : '0;
    v.site  = held > 0 ? hk_site[0] : '0;
    v.total = cnt_t'(held);
    return v;
  endfunction

  // result checker
  always @(posedge clk) begin
    heap_view_t w;
    if (!rst && done) begin
      if (pending_roots.size() == 0) begin
        $display("%0t: unexpected result key=%h site=%0d total=%0d rej=%b", $time,
                 root_key, root_site, entry_total, rejected);
        errors++;
      end else begin
        w = pending_roots.pop_front();
        if (root_key !== w.key) begin
          $display("%0t: root_key exp %h got %h", $time, w.key, root_key); errors++;
        end
        if (root_site !== w.site) begin
          $display("%0t: root_site exp %0d got %0d", $time, w.site, root_site); errors++;
        end
        if (entry_total !== w.total) begin
          $display("%0t: entry_total exp %0d got %0d", $time, w.total, entry_total);
          errors++;
        end
        if (rejected !== w.rej) begin
          $display("%0t: rejected exp %b got %b", $time, w.rej, rejected); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // drive one word; returns at the falling edge after it is accepted, start still high
  task automatic send_word(mode_t md, site_t st, key_t k, key_t off, int gap_pct,
                           bit fixed, heap_view_t want);
    heap_view_t v;
    while ($urandom_range(99) < gap_pct) begin
      start <= 0;
      @(negedge clk);
    end
    start <= 1; mode <= md; site <= st; new_key <= k; offset <= off;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    v = apply_word(md, st, k, off);
    pending_roots.push_back(fixed ? want : v);
    @(negedge clk);
  endtask

  function automatic key_t pick_key();
    case ($urandom_range(3))
      0: return key_t'($urandom_range(7));
      1: return key_t'({$urandom, $urandom});
      2: return key_t'({$urandom_range(255), 24'h0});
      default: return {KEY_BITS{1'b1}} - key_t'($urandom_range(3));
    endcase
  endfunction

  function automatic site_t known_site();
    site_t s;
    do s = site_t'($urandom); while (!site_known[s]);
    return s;
  endfunction

  word_row_t opening[$];
  int gap;

  initial begin
    heap_view_t z;
    word_row_t r;
    foreach (site_known[i]) site_known[i] = 0;
    z = '{key: '0, site: '0, total: '0, rej: 0};
    // empty heap, full-scale first entry, zero key, saturating subtract
    opening.push_back('{MODE_NONE, '1, '1, '1, 1, z});
    opening.push_back('{MODE_OFFSET, '0, '0, '1, 1, z});
    opening.push_back('{MODE_INSERT, 10'd1023, '1, '0, 1,
                        '{key: '1, site: 10'd1023, total: 11'd1, rej: 0}});
    opening.push_back('{MODE_INSERT, 10'd0, '0, '1, 1,
                        '{key: '0, site: 10'd0, total: 11'd2, rej: 0}});
    opening.push_back('{MODE_OFFSET, '0, '0, '1, 1,
                        '{key: '0, site: 10'd0, total: 11'd2, rej: 0}});
    // predictor rows: ties, duplicates, up and down moves, equal update
    opening.push_back('{MODE_INSERT, 10'd5, 40'd0, '0, 0, z});
    opening.push_back('{MODE_INSERT, 10'd7, 40'd9, '0, 0, z});
    opening.push_back('{MODE_INSERT, 10'd3, 40'd9, '0, 0, z});
    opening.push_back('{MODE_UPDATE, 10'd0, 40'd20, '0, 0, z});
    opening.push_back('{MODE_UPDATE, 10'd5, 40'd20, '0, 0, z});
    opening.push_back('{MODE_UPDATE, 10'd7, 40'd9, '0, 0, z});
    opening.push_back('{MODE_UPDATE, 10'd7, 40'd1, '0, 0, z});
    opening.push_back('{MODE_INSERT, 10'd7, 40'd30, '0, 0, z});
    opening.push_back('{MODE_UPDATE, 10'd7, 40'd0, '0, 0, z});
    opening.push_back('{MODE_UPDATE, 10'd1023, 40'd2, '0, 0, z});
    opening.push_back('{MODE_OFFSET, '0, '0, 40'd1, 0, z});
    opening.push_back('{MODE_NONE, 10'h2aa, 40'h55_5555_5555, 40'haa_aaaa_aaaa, 0, z});
    opening.push_back('{MODE_UPDATE, 10'd3, '1, '0, 0, z});

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    foreach (opening[i]) begin
      r = opening[i];
      send_word(r.md, r.st, r.k, r.off, 23, r.fixed, r.want);
    end

    // random mix; heap fills up late, so full-heap rejects appear near the end
    for (int n = 0; n < 1900; n++) begin
      int pick;
      gap = n < 633 ? 23 : (n < 1266 ? 45 : 0);
      pick = $urandom_range(99);
      if (pick < 56)
        send_word(MODE_INSERT, site_t'($urandom), pick_key(), key_t'($urandom), gap, 0, z);
      else if (pick < 90)
        send_word(MODE_UPDATE, known_site(), pick_key(), key_t'($urandom), gap, 0, z);
      else if (pick < 97)
        send_word(MODE_OFFSET, site_t'($urandom), key_t'($urandom),
                  $urandom_range(9) == 0 ? pick_key() : key_t'($urandom_range(15)), gap, 0, z);
      else
        send_word(MODE_NONE, site_t'($urandom), pick_key(), pick_key(), gap, 0, z);
    end
    start <= 0;

    while (pending_roots.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && pending_roots.size() == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
